// ----- design/scfb_pkg.sv -----
// ----------------------------------------------------------------------------
// scfb_pkg
// Types, widths and codes shared by the split channel front buffer modules.
// ----------------------------------------------------------------------------
package scfb_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int PENDING_DEPTH_DEF = 8;

	localparam int ADDR_W     = 32;
	localparam int TYPE_W     = 2;
	localparam int KIND_W     = 3;
	localparam int CAP_W      = 24;
	localparam int CMDB_W     = 13;
	localparam int PAGE_W     = 24;
	localparam int CHW_W      = 11;
	localparam int USED_W     = 25;
	localparam int CYC_W      = 25;
	localparam int DIVN_W     = 26;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int RES_MAX    = 3;

	localparam logic [TYPE_W-1:0] TT_READ   = 2'd0;
	localparam logic [TYPE_W-1:0] TT_WRITE  = 2'd1;
	localparam logic [TYPE_W-1:0] TT_RETURN = 2'd2;

	localparam logic [KIND_W-1:0] RK_REFUSED  = 3'd0;
	localparam logic [KIND_W-1:0] RK_ACCEPTED = 3'd1;
	localparam logic [KIND_W-1:0] RK_TO_FTL   = 3'd2;
	localparam logic [KIND_W-1:0] RK_TO_HOST  = 3'd3;
	localparam logic [KIND_W-1:0] RK_NONE     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REQ_CAP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RSP_CAP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_BITS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SH_W     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RQ_W     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CM_W     = 3'd7;

	typedef struct packed {
		logic                command;
		logic [TYPE_W-1:0]   txn_type;
		logic [ADDR_W-1:0]   address;
		logic                ftl_ready;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]   result_kind;
		logic [ADDR_W-1:0]   out_address;
		logic [TYPE_W-1:0]   out_type;
		logic                last;
	} result_t;

	typedef struct packed {
		logic [1:0]          mode;
		logic [CAP_W-1:0]    req_cap;
		logic [CAP_W-1:0]    rsp_cap;
		logic [CMDB_W-1:0]   cmd_bits;
		logic [PAGE_W-1:0]   page_bits;
		logic [CHW_W-1:0]    sh_w;
		logic [CHW_W-1:0]    rq_w;
		logic [CHW_W-1:0]    cm_w;
	} cfg_t;

	typedef enum logic [1:0] {
		IK_TICK    = 2'd0,
		IK_ADD_REQ = 2'd1,
		IK_ADD_RSP = 2'd2,
		IK_ADD_BAD = 2'd3
	} item_kind_t;

	typedef struct packed {
		item_kind_t          kind;
		logic [TYPE_W-1:0]   txn_type;
		logic [ADDR_W-1:0]   address;
		logic                ftl_ready;
	} work_t;

	typedef struct packed {
		logic                start;
		logic [CYC_W-1:0]    num;
		logic [CHW_W-1:0]    den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [CYC_W-1:0]    quo;
	} div_rsp_t;

endpackage

// ----- design/scfb_front.sv -----
// ----------------------------------------------------------------------------
// scfb_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module scfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  scfb_pkg::item_t   item,
	output logic              work_valid,
	input  logic              work_ready,
	output scfb_pkg::work_t   work
);

	scfb_pkg::work_t fifo_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;
	scfb_pkg::work_t cls;

	assign item_ready = (cnt_q != 2'd2);
	assign work_valid = (cnt_q != 2'd0);
	assign work       = fifo_q[rd_q];
	assign push       = item_valid && item_ready;
	assign pop        = work_valid && work_ready;

	always_comb begin
		cls.txn_type  = item.txn_type;
		cls.address   = item.address;
		cls.ftl_ready = item.ftl_ready;
		if (!item.command) begin
			cls.kind = scfb_pkg::IK_TICK;
		end else if (item.txn_type == scfb_pkg::TT_READ || item.txn_type == scfb_pkg::TT_WRITE) begin
			cls.kind = scfb_pkg::IK_ADD_REQ;
		end else if (item.txn_type == scfb_pkg::TT_RETURN) begin
			cls.kind = scfb_pkg::IK_ADD_RSP;
		end else begin
			cls.kind = scfb_pkg::IK_ADD_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				fifo_q[wr_q] <= cls;
				wr_q         <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- design/scfb_div.sv -----
// ----------------------------------------------------------------------------
// scfb_div
// Bit-serial ceiling divider for channel transfer cycle counts.
// ----------------------------------------------------------------------------
module scfb_div (
	input  logic                clk,
	input  logic                arst_n,
	input  scfb_pkg::div_req_t  req,
	output scfb_pkg::div_rsp_t  rsp
);

	localparam int CNT_W = $clog2(scfb_pkg::DIVN_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [scfb_pkg::CHW_W-1:0]    rem_q;
	logic [scfb_pkg::CHW_W-1:0]    den_q;
	logic [scfb_pkg::DIVN_W-1:0]   dvd_q;
	logic [scfb_pkg::CHW_W-1:0]    d_eff;
	logic [scfb_pkg::CHW_W:0]      t;
	logic [scfb_pkg::CHW_W:0]      sub;
	logic                          ge;

	assign d_eff = (req.den == '0) ? scfb_pkg::CHW_W'(1) : req.den;
	assign t     = {rem_q, dvd_q[scfb_pkg::DIVN_W-1]};
	assign sub   = t - {1'b0, den_q};
	assign ge    = (t >= {1'b0, den_q});

	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q[scfb_pkg::CYC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				den_q  <= d_eff;
				dvd_q  <= scfb_pkg::DIVN_W'(req.num) + scfb_pkg::DIVN_W'(d_eff)
					- scfb_pkg::DIVN_W'(1);
			end else if (busy_q) begin
				rem_q <= ge ? sub[scfb_pkg::CHW_W-1:0] : t[scfb_pkg::CHW_W-1:0];
				dvd_q <= {dvd_q[scfb_pkg::DIVN_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(scfb_pkg::DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- design/scfb_back.sv -----
// ----------------------------------------------------------------------------
// scfb_back
// Admission, queues, channel sequencing, pending-list join and result drain.
// ----------------------------------------------------------------------------
module scfb_back #(
	parameter int QUEUE_DEPTH   = scfb_pkg::QUEUE_DEPTH_DEF,
	parameter int PENDING_DEPTH = scfb_pkg::PENDING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scfb_pkg::cfg_t      cfg,
	input  logic                work_valid,
	output logic                work_ready,
	input  scfb_pkg::work_t     work,
	output logic                result_valid,
	input  logic                result_ready,
	output scfb_pkg::result_t   result,
	output scfb_pkg::div_req_t  div_req,
	input  scfb_pkg::div_rsp_t  div_rsp
);

	localparam int QIW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCW = $clog2(PENDING_DEPTH + 1);
	localparam int AW  = scfb_pkg::ADDR_W;
	localparam int UW  = scfb_pkg::USED_W;
	localparam int CW  = scfb_pkg::CYC_W;
	localparam int TW  = scfb_pkg::TYPE_W;
	localparam logic [QCW-1:0] Q_FULL = QCW'(QUEUE_DEPTH);
	localparam logic [PCW-1:0] P_FULL = PCW'(PENDING_DEPTH);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_ADD   = 10'b0000000010,
		ST_CHSEL = 10'b0000000100,
		ST_ADV   = 10'b0000001000,
		ST_DIVW  = 10'b0000010000,
		ST_FIN   = 10'b0000100000,
		ST_JOIN  = 10'b0001000000,
		ST_END   = 10'b0010000000,
		ST_DRAIN = 10'b0100000000,
		ST_SPARE = 10'b1000000000
	} st_t;

	typedef struct packed {
		logic [scfb_pkg::KIND_W-1:0] kind;
		logic [AW-1:0]               addr;
		logic [TW-1:0]               ttype;
	} res_t;

	st_t               st_q;
	scfb_pkg::work_t   item_q;
	logic [1:0]        ch_q;

	// queues
	logic [AW:0]       rq_mem [QUEUE_DEPTH];
	logic [AW-1:0]     rs_mem [QUEUE_DEPTH];
	logic [AW:0]       cq_mem [QUEUE_DEPTH];
	logic [AW:0]       rq_rd_q;
	logic [AW-1:0]     rs_rd_q;
	logic [AW:0]       cq_rd_q;
	logic [QIW-1:0]    rq_head_q, rs_head_q, cq_head_q;
	logic [QCW-1:0]    rq_cnt_q, rs_cnt_q, cq_cnt_q;
	logic              rq_we, rs_we, cq_we;

	logic [UW-1:0]     req_used_q, rsp_used_q;

	// channels
	logic              ch_v_q [3];
	logic [TW-1:0]     ch_t_q [3];
	logic [AW-1:0]     ch_a_q [3];
	logic [CW-1:0]     left_q [3];

	// pending lists
	logic [AW-1:0]          pd_list_q [PENDING_DEPTH];
	logic [AW-1:0]          pc_list_q [PENDING_DEPTH];
	logic [PCW-1:0]         pd_cnt_q, pc_cnt_q;
	logic [PENDING_DEPTH-1:0] pd_hit, pc_hit, pd_hit_q, pc_hit_q;

	// results
	res_t              res_q [scfb_pkg::RES_MAX];
	logic [1:0]        res_n_q;
	logic [1:0]        drain_q;
	logic              out_v_q;
	scfb_pkg::result_t out_q;

	logic              cmd_on, req_on, ftl;
	logic [UW-1:0]     cost, dq_cost;
	logic              req_ok, rsp_ok, adm;
	logic              ch_en, pop_rs, pop_rq, pop_cq;
	logic [TW-1:0]     cur_t;
	logic [AW-1:0]     cur_a;
	logic [CW-1:0]     cur_left;
	logic              slot_free;
	logic              last_ch;

	function automatic logic [QIW-1:0] q_tail(logic [QIW-1:0] head, logic [QCW-1:0] cnt);
		logic [QCW:0] s;
		s = (QCW+1)'(head) + (QCW+1)'(cnt);
		if (s >= (QCW+1)'(QUEUE_DEPTH)) begin
			s = s - (QCW+1)'(QUEUE_DEPTH);
		end
		return s[QIW-1:0];
	endfunction

	function automatic logic [QIW-1:0] q_next(logic [QIW-1:0] head);
		return (head == QIW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
	endfunction

	function automatic logic [UW-1:0] sat_sub(logic [UW-1:0] a, logic [UW-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	function automatic logic [PIW-1:0] first_hit(logic [PENDING_DEPTH-1:0] h);
		logic [PIW-1:0] idx;
		idx = '0;
		for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
			if (h[i]) begin
				idx = PIW'(i);
			end
		end
		return idx;
	endfunction

	assign cmd_on = cfg.mode[1];
	assign req_on = cfg.mode[0];
	assign ftl    = item_q.ftl_ready;

	// admission
	always_comb begin
		cost   = UW'(cfg.cmd_bits)
			+ ((item_q.txn_type == scfb_pkg::TT_WRITE) ? UW'(cfg.page_bits) : '0);
		req_ok = (rq_cnt_q < Q_FULL) && (!cmd_on || cq_cnt_q < Q_FULL)
			&& ({1'b0, req_used_q} + {1'b0, cost} <= (UW+1)'(cfg.req_cap));
		rsp_ok = (rs_cnt_q < Q_FULL)
			&& ({1'b0, rsp_used_q} + (UW+1)'(cfg.page_bits) <= (UW+1)'(cfg.rsp_cap));
		adm    = (item_q.kind == scfb_pkg::IK_ADD_REQ && req_ok)
			|| (item_q.kind == scfb_pkg::IK_ADD_RSP && rsp_ok);
		dq_cost = cmd_on ? UW'(cfg.page_bits) : UW'(cfg.page_bits) + UW'(cfg.cmd_bits);
	end

	assign rq_we = (st_q == ST_ADD) && (item_q.kind == scfb_pkg::IK_ADD_REQ) && req_ok;
	assign cq_we = rq_we && cmd_on;
	assign rs_we = (st_q == ST_ADD) && (item_q.kind == scfb_pkg::IK_ADD_RSP) && rsp_ok;

	// channel selection
	assign cur_t    = ch_t_q[ch_q];
	assign cur_a    = ch_a_q[ch_q];
	assign cur_left = left_q[ch_q];
	assign last_ch  = (ch_q == 2'd2);

	always_comb begin
		ch_en  = (ch_q == 2'd0) || (ch_q == 2'd1 && req_on) || (ch_q == 2'd2 && cmd_on);
		pop_rs = (ch_q == 2'd0) && !ch_v_q[0] && (rs_cnt_q != '0);
		pop_rq = ((ch_q == 2'd0) && !ch_v_q[0] && (rs_cnt_q == '0) && !req_on
			&& (rq_cnt_q != '0)) || ((ch_q == 2'd1) && !ch_v_q[1] && (rq_cnt_q != '0));
		pop_cq = (ch_q == 2'd2) && !ch_v_q[2] && (cq_cnt_q != '0);
	end

	// cycle count request
	always_comb begin
		div_req.start = (st_q == ST_ADV) && (cur_left == '0);
		unique case (ch_q)
			2'd0:    div_req.den = cfg.sh_w;
			2'd1:    div_req.den = cfg.rq_w;
			default: div_req.den = cfg.cm_w;
		endcase
		if (ch_q == 2'd2) begin
			div_req.num = CW'(cfg.cmd_bits);
		end else if (cur_t == scfb_pkg::TT_READ) begin
			div_req.num = cmd_on ? CW'(1) : CW'(cfg.cmd_bits);
		end else if (cur_t == scfb_pkg::TT_WRITE) begin
			div_req.num = cmd_on ? CW'(cfg.page_bits) : CW'(cfg.page_bits) + CW'(cfg.cmd_bits);
		end else begin
			div_req.num = CW'(cfg.page_bits);
		end
	end

	// address match against both lists
	always_comb begin
		for (int i = 0; i < PENDING_DEPTH; i++) begin
			pd_hit[i] = (PCW'(i) < pd_cnt_q) && (pd_list_q[i] == cur_a);
			pc_hit[i] = (PCW'(i) < pc_cnt_q) && (pc_list_q[i] == cur_a);
		end
	end

	assign work_ready   = (st_q == ST_IDLE);
	assign slot_free    = !out_v_q || result_ready;
	assign result_valid = out_v_q;
	assign result       = out_q;

	// queue storage
	always_ff @(posedge clk) begin
		if (rq_we) begin
			rq_mem[q_tail(rq_head_q, rq_cnt_q)] <= {item_q.txn_type[0], item_q.address};
		end
		rq_rd_q <= rq_mem[rq_head_q];
	end

	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[q_tail(rs_head_q, rs_cnt_q)] <= item_q.address;
		end
		rs_rd_q <= rs_mem[rs_head_q];
	end

	always_ff @(posedge clk) begin
		if (cq_we) begin
			cq_mem[q_tail(cq_head_q, cq_cnt_q)] <= {item_q.txn_type[0], item_q.address};
		end
		cq_rd_q <= cq_mem[cq_head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			ch_q       <= 2'd0;
			rq_head_q  <= '0;
			rs_head_q  <= '0;
			cq_head_q  <= '0;
			rq_cnt_q   <= '0;
			rs_cnt_q   <= '0;
			cq_cnt_q   <= '0;
			req_used_q <= '0;
			rsp_used_q <= '0;
			pd_cnt_q   <= '0;
			pc_cnt_q   <= '0;
			res_n_q    <= 2'd0;
			drain_q    <= 2'd0;
			out_v_q    <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				ch_v_q[c] <= 1'b0;
				left_q[c] <= '0;
			end
		end else begin
			if (st_q == ST_DRAIN && slot_free) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (work_valid) begin
						item_q  <= work;
						res_n_q <= 2'd0;
						ch_q    <= 2'd0;
						st_q    <= (work.kind == scfb_pkg::IK_TICK) ? ST_CHSEL : ST_ADD;
					end
				end
				ST_ADD: begin
					res_q[0] <= '{kind: adm ? scfb_pkg::RK_ACCEPTED : scfb_pkg::RK_REFUSED,
						addr: item_q.address, ttype: item_q.txn_type};
					res_n_q  <= 2'd1;
					drain_q  <= 2'd0;
					if (rq_we) begin
						rq_cnt_q   <= rq_cnt_q + 1'b1;
						req_used_q <= req_used_q + cost;
					end
					if (cq_we) begin
						cq_cnt_q <= cq_cnt_q + 1'b1;
					end
					if (rs_we) begin
						rs_cnt_q   <= rs_cnt_q + 1'b1;
						rsp_used_q <= rsp_used_q + UW'(cfg.page_bits);
					end
					st_q <= ST_DRAIN;
				end
				ST_CHSEL: begin
					if (ch_en && ch_v_q[ch_q]) begin
						st_q <= ST_ADV;
					end else if (ch_en && pop_rs) begin
						ch_v_q[0]  <= 1'b1;
						ch_t_q[0]  <= scfb_pkg::TT_RETURN;
						ch_a_q[0]  <= rs_rd_q;
						rs_head_q  <= q_next(rs_head_q);
						rs_cnt_q   <= rs_cnt_q - 1'b1;
						rsp_used_q <= sat_sub(rsp_used_q, UW'(cfg.page_bits));
						st_q       <= ST_ADV;
					end else if (ch_en && pop_rq) begin
						ch_v_q[ch_q] <= 1'b1;
						ch_t_q[ch_q] <= {1'b0, rq_rd_q[AW]};
						ch_a_q[ch_q] <= rq_rd_q[AW-1:0];
						rq_head_q    <= q_next(rq_head_q);
						rq_cnt_q     <= rq_cnt_q - 1'b1;
						req_used_q   <= sat_sub(req_used_q, dq_cost);
						st_q         <= ST_ADV;
					end else if (ch_en && pop_cq) begin
						ch_v_q[2]  <= 1'b1;
						ch_t_q[2]  <= {1'b0, cq_rd_q[AW]};
						ch_a_q[2]  <= cq_rd_q[AW-1:0];
						cq_head_q  <= q_next(cq_head_q);
						cq_cnt_q   <= cq_cnt_q - 1'b1;
						req_used_q <= sat_sub(req_used_q, UW'(cfg.cmd_bits));
						st_q       <= ST_ADV;
					end else begin
						if (!last_ch) ch_q <= ch_q + 2'd1;
						st_q <= last_ch ? ST_END : ST_CHSEL;
					end
				end
				ST_ADV: begin
					if (cur_left == '0) begin
						st_q <= ST_DIVW;
					end else begin
						left_q[ch_q] <= cur_left - 1'b1;
						if (cur_left == CW'(1)) begin
							st_q <= ST_FIN;
						end else begin
							if (!last_ch) ch_q <= ch_q + 2'd1;
							st_q <= last_ch ? ST_END : ST_CHSEL;
						end
					end
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						if (div_rsp.quo == '0) begin
							st_q <= ST_FIN;
						end else begin
							left_q[ch_q] <= div_rsp.quo - 1'b1;
							if (div_rsp.quo == CW'(1)) begin
								st_q <= ST_FIN;
							end else begin
								if (!last_ch) ch_q <= ch_q + 2'd1;
								st_q <= last_ch ? ST_END : ST_CHSEL;
							end
						end
					end
				end
				ST_FIN: begin
					pd_hit_q <= pd_hit;
					pc_hit_q <= pc_hit;
					st_q     <= ST_JOIN;
				end
				ST_JOIN: begin
					if (ch_q == 2'd2) begin
						if (|pc_hit_q) begin
							if (ftl) begin
								res_q[res_n_q] <= '{kind: scfb_pkg::RK_TO_FTL, addr: cur_a,
									ttype: cur_t};
								res_n_q   <= res_n_q + 2'd1;
								ch_v_q[2] <= 1'b0;
								for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
									if (PIW'(i) >= first_hit(pc_hit_q)) begin
										pc_list_q[i] <= pc_list_q[i+1];
									end
								end
								pc_cnt_q <= pc_cnt_q - 1'b1;
							end
						end else if (pd_cnt_q < P_FULL) begin
							pd_list_q[pd_cnt_q[PIW-1:0]] <= cur_a;
							pd_cnt_q  <= pd_cnt_q + 1'b1;
							ch_v_q[2] <= 1'b0;
						end
					end else if (ch_q == 2'd0 && cur_t == scfb_pkg::TT_RETURN) begin
						res_q[res_n_q] <= '{kind: scfb_pkg::RK_TO_HOST, addr: cur_a,
							ttype: scfb_pkg::TT_RETURN};
						res_n_q   <= res_n_q + 2'd1;
						ch_v_q[0] <= 1'b0;
					end else if (cmd_on) begin
						if (|pd_hit_q) begin
							if (ftl) begin
								res_q[res_n_q] <= '{kind: scfb_pkg::RK_TO_FTL, addr: cur_a,
									ttype: cur_t};
								res_n_q      <= res_n_q + 2'd1;
								ch_v_q[ch_q] <= 1'b0;
								for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
									if (PIW'(i) >= first_hit(pd_hit_q)) begin
										pd_list_q[i] <= pd_list_q[i+1];
									end
								end
								pd_cnt_q <= pd_cnt_q - 1'b1;
							end
						end else if (pc_cnt_q < P_FULL) begin
							pc_list_q[pc_cnt_q[PIW-1:0]] <= cur_a;
							pc_cnt_q     <= pc_cnt_q + 1'b1;
							ch_v_q[ch_q] <= 1'b0;
						end
					end else if (ftl) begin
						res_q[res_n_q] <= '{kind: scfb_pkg::RK_TO_FTL, addr: cur_a, ttype: cur_t};
						res_n_q      <= res_n_q + 2'd1;
						ch_v_q[ch_q] <= 1'b0;
					end
					if (!last_ch) ch_q <= ch_q + 2'd1;
					st_q <= last_ch ? ST_END : ST_CHSEL;
				end
				ST_END: begin
					if (res_n_q == 2'd0) begin
						res_q[0] <= '{kind: scfb_pkg::RK_NONE, addr: '0, ttype: '0};
						res_n_q  <= 2'd1;
					end
					drain_q <= 2'd0;
					st_q    <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (slot_free) begin
						out_q.result_kind <= res_q[drain_q].kind;
						out_q.out_address <= res_q[drain_q].addr;
						out_q.out_type    <= res_q[drain_q].ttype;
						out_q.last        <= (drain_q == res_n_q - 2'd1);
						if (drain_q == res_n_q - 2'd1) begin
							st_q <= ST_IDLE;
						end else begin
							drain_q <= drain_q + 2'd1;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// occupancy never exceeds the storage
	assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= Q_FULL && rs_cnt_q <= Q_FULL && cq_cnt_q <= Q_FULL)
		else $error("queue count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		pd_cnt_q <= P_FULL && pc_cnt_q <= P_FULL)
		else $error("pending list count above depth");

	// a drain always has at least one word to send
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DRAIN) |-> (res_n_q != 2'd0 && drain_q < res_n_q))
		else $error("drain with no result");

	// divider answers only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (st_q == ST_DIVW))
		else $error("unexpected divider done");

endmodule

// ----- design/split_channel_front_buffer_core.sv -----
// ----------------------------------------------------------------------------
// split_channel_front_buffer_core
// Front buffer of a memory module: admission, channel timing and joining.
// ----------------------------------------------------------------------------
// sequence: an add word goes through ST_ADD and ST_DRAIN to its registered result
// a tick visits each channel in ST_CHSEL and ST_ADV, waits in ST_DIVW for the
// divider when a channel starts a transfer and passes ST_FIN and ST_JOIN when
// one finishes; ST_DRAIN then sends a result word per cycle while not stalled
// throughput: one word at a time in the back end, words queue two deep in front
// reset: asynchronous, clears queues, budgets, channels and pending lists
// ----------------------------------------------------------------------------
module split_channel_front_buffer_core #(
	parameter int QUEUE_DEPTH   = scfb_pkg::QUEUE_DEPTH_DEF,
	parameter int PENDING_DEPTH = scfb_pkg::PENDING_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  scfb_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output scfb_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [scfb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	scfb_pkg::cfg_t     cfg_q;
	scfb_pkg::work_t    work;
	logic               work_valid;
	logic               work_ready;
	scfb_pkg::div_req_t div_req;
	scfb_pkg::div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= 2'd0;
			cfg_q.req_cap   <= 24'd1048576;
			cfg_q.rsp_cap   <= 24'd1048576;
			cfg_q.cmd_bits  <= 13'd64;
			cfg_q.page_bits <= 24'd32768;
			cfg_q.sh_w      <= 11'd64;
			cfg_q.rq_w      <= 11'd64;
			cfg_q.cm_w      <= 11'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scfb_pkg::CFG_MODE:     cfg_q.mode      <= cfg_data[1:0];
				scfb_pkg::CFG_REQ_CAP:  cfg_q.req_cap   <= cfg_data;
				scfb_pkg::CFG_RSP_CAP:  cfg_q.rsp_cap   <= cfg_data;
				scfb_pkg::CFG_CMD_BITS: cfg_q.cmd_bits  <= cfg_data[scfb_pkg::CMDB_W-1:0];
				scfb_pkg::CFG_PAGE:     cfg_q.page_bits <= cfg_data;
				scfb_pkg::CFG_SH_W:     cfg_q.sh_w      <= cfg_data[scfb_pkg::CHW_W-1:0];
				scfb_pkg::CFG_RQ_W:     cfg_q.rq_w      <= cfg_data[scfb_pkg::CHW_W-1:0];
				scfb_pkg::CFG_CM_W:     cfg_q.cm_w      <= cfg_data[scfb_pkg::CHW_W-1:0];
				default:                cfg_q.mode      <= cfg_q.mode;
			endcase
		end
	end

	scfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.work_valid (work_valid),
		.work_ready (work_ready),
		.work       (work)
	);

	scfb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	scfb_back #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.work_valid   (work_valid),
		.work_ready   (work_ready),
		.work         (work),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the split channel front buffer. A scoreboard class
// predicts admission, channel timing, joining and delivery for every accepted
// word and checks each result word in order. Several register settings are
// run with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QDEPTH    = scfb_pkg::QUEUE_DEPTH_DEF;
	localparam int PDEPTH    = scfb_pkg::PENDING_DEPTH_DEF;
	localparam int NPHASE    = 7;
	localparam int WDOG_MAX  = 20000;
	localparam logic [scfb_pkg::CFG_IDX_W-1:0] REG_IDX [8] = '{scfb_pkg::CFG_MODE,
		scfb_pkg::CFG_REQ_CAP, scfb_pkg::CFG_RSP_CAP, scfb_pkg::CFG_CMD_BITS,
		scfb_pkg::CFG_PAGE, scfb_pkg::CFG_SH_W, scfb_pkg::CFG_RQ_W, scfb_pkg::CFG_CM_W};

	typedef struct {
		bit          v;
		bit [1:0]    ty;
		bit [31:0]   a;
	} sb_txn_t;

	class front_buffer_sb_t;
		bit [1:0]          mode;
		bit [23:0]         req_cap, rsp_cap, page;
		bit [12:0]         cmdb;
		bit [10:0]         shw, rqw, cmw;
		sb_txn_t           req_q[$], rsp_q[$], cmd_q[$];
		sb_txn_t           pend_data[$], pend_cmd[$];
		sb_txn_t           chan[3];
		longint unsigned   left[3];
		longint unsigned   req_used, rsp_used;
		bit                ftl_ok;
		scfb_pkg::result_t step_res[$];
		scfb_pkg::result_t expected[$];
		int                errors;

		function new();
			mode = 0; req_cap = 1048576; rsp_cap = 1048576; cmdb = 64; page = 32768;
			shw = 64; rqw = 64; cmw = 16;
			req_used = 0; rsp_used = 0; errors = 0;
			for (int i = 0; i < 3; i++) begin
				chan[i] = '{0, 0, 0};
				left[i] = 0;
			end
		endfunction

		function void set_reg(logic [scfb_pkg::CFG_IDX_W-1:0] idx, logic [23:0] d);
			case (idx)
				scfb_pkg::CFG_MODE:     mode = d[1:0];
				scfb_pkg::CFG_REQ_CAP:  req_cap = d;
				scfb_pkg::CFG_RSP_CAP:  rsp_cap = d;
				scfb_pkg::CFG_CMD_BITS: cmdb = d[12:0];
				scfb_pkg::CFG_PAGE:     page = d;
				scfb_pkg::CFG_SH_W:     shw = d[10:0];
				scfb_pkg::CFG_RQ_W:     rqw = d[10:0];
				scfb_pkg::CFG_CM_W:     cmw = d[10:0];
				default: ;
			endcase
		endfunction

		function void emit(logic [scfb_pkg::KIND_W-1:0] k, bit [31:0] a, bit [1:0] t);
			scfb_pkg::result_t r;
			if (step_res.size() >= scfb_pkg::RES_MAX) return;
			r.result_kind = k;
			r.out_address = a;
			r.out_type = t;
			r.last = 0;
			step_res = {step_res, r};
		endfunction

		function longint unsigned cdiv(longint unsigned n, longint unsigned d);
			if (d == 0) d = 1;
			return (n + d - 1) / d;
		endfunction

		function longint unsigned sat_sub(longint unsigned a, longint unsigned b);
			return a > b ? a - b : 0;
		endfunction

		function longint unsigned xfer_cycles(bit [1:0] t, longint unsigned w);
			if (t == scfb_pkg::TT_READ) return mode[1] ? 1 : cdiv(cmdb, w);
			if (t == scfb_pkg::TT_WRITE)
				return mode[1] ? cdiv(page, w) : cdiv(longint'(page) + cmdb, w);
			return cdiv(page, w);
		endfunction

		function int find_addr(sb_txn_t l[$], bit [31:0] a);
			foreach (l[i])
				if (l[i].a == a) return i;
			return -1;
		endfunction

		function void finish_data(int ch);
			int idx;
			if (mode[1]) begin
				idx = find_addr(pend_data, chan[ch].a);
				if (idx >= 0) begin
					if (ftl_ok) begin
						emit(scfb_pkg::RK_TO_FTL, chan[ch].a, chan[ch].ty);
						chan[ch].v = 0;
						pend_data.delete(idx);
					end
				end else if (pend_cmd.size() < PDEPTH) begin
					pend_cmd = {pend_cmd, chan[ch]};
					chan[ch].v = 0;
				end
			end else if (ftl_ok) begin
				emit(scfb_pkg::RK_TO_FTL, chan[ch].a, chan[ch].ty);
				chan[ch].v = 0;
			end
		endfunction

		function void finish_cmd();
			int idx;
			idx = find_addr(pend_cmd, chan[2].a);
			if (idx >= 0) begin
				if (ftl_ok) begin
					emit(scfb_pkg::RK_TO_FTL, chan[2].a, chan[2].ty);
					chan[2].v = 0;
					pend_cmd.delete(idx);
				end
			end else if (pend_data.size() < PDEPTH) begin
				pend_data = {pend_data, chan[2]};
				chan[2].v = 0;
			end
		endfunction

		function void advance(int ch);
			if (left[ch] == 0) begin
				if (ch == 0)
					left[ch] = chan[0].ty == scfb_pkg::TT_RETURN ? cdiv(page, shw)
						: xfer_cycles(chan[0].ty, shw);
				else if (ch == 1)
					left[ch] = xfer_cycles(chan[1].ty, rqw);
				else
					left[ch] = cdiv(cmdb, cmw);
			end
			if (left[ch] > 0) left[ch]--;
			if (left[ch] != 0) return;
			if (ch == 2) finish_cmd();
			else if (ch == 0 && chan[0].ty == scfb_pkg::TT_RETURN) begin
				emit(scfb_pkg::RK_TO_HOST, chan[0].a, scfb_pkg::TT_RETURN);
				chan[0].v = 0;
			end else finish_data(ch);
		endfunction

		function longint unsigned req_take_cost();
			return mode[1] ? longint'(page) : longint'(page) + cmdb;
		endfunction

		function void note_item(scfb_pkg::item_t it);
			sb_txn_t t;
			bit ok;
			longint unsigned cost;
			step_res.delete();
			ftl_ok = it.ftl_ready;
			if (it.command) begin
				ok = 0;
				t = '{1, it.txn_type, it.address};
				if (it.txn_type == scfb_pkg::TT_READ || it.txn_type == scfb_pkg::TT_WRITE) begin
					cost = cmdb + (it.txn_type == scfb_pkg::TT_WRITE ? longint'(page) : 0);
					if (req_q.size() < QDEPTH && (!mode[1] || cmd_q.size() < QDEPTH) &&
						req_used + cost <= req_cap) begin
						req_q = {req_q, t};
						if (mode[1]) cmd_q = {cmd_q, t};
						req_used += cost;
						ok = 1;
					end
				end else if (it.txn_type == scfb_pkg::TT_RETURN) begin
					if (rsp_q.size() < QDEPTH && rsp_used + page <= rsp_cap) begin
						rsp_q = {rsp_q, t};
						rsp_used += page;
						ok = 1;
					end
				end
				emit(ok ? scfb_pkg::RK_ACCEPTED : scfb_pkg::RK_REFUSED, it.address, it.txn_type);
			end else begin
				if (chan[0].v) advance(0);
				else if (rsp_q.size() > 0) begin
					chan[0] = rsp_q.pop_front();
					rsp_used = sat_sub(rsp_used, page);
					advance(0);
				end else if (!mode[0] && req_q.size() > 0) begin
					chan[0] = req_q.pop_front();
					req_used = sat_sub(req_used, req_take_cost());
					advance(0);
				end
				if (mode[0]) begin
					if (chan[1].v) advance(1);
					else if (req_q.size() > 0) begin
						chan[1] = req_q.pop_front();
						req_used = sat_sub(req_used, req_take_cost());
						advance(1);
					end
				end
				if (mode[1]) begin
					if (chan[2].v) advance(2);
					else if (cmd_q.size() > 0) begin
						chan[2] = cmd_q.pop_front();
						req_used = sat_sub(req_used, cmdb);
						advance(2);
					end
				end
				if (step_res.size() == 0) emit(scfb_pkg::RK_NONE, 0, 0);
			end
			step_res[step_res.size() - 1].last = 1;
			foreach (step_res[i]) expected = {expected, step_res[i]};
		endfunction

		function void check_result(scfb_pkg::result_t r);
			scfb_pkg::result_t e;
			if (expected.size() == 0) begin
				$error("unexpected result word kind %0d address %h", r.result_kind, r.out_address);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (r.result_kind !== e.result_kind) begin
				$error("result_kind expected %0d actual %0d", e.result_kind, r.result_kind);
				errors++;
			end
			if (r.out_address !== e.out_address) begin
				$error("out_address expected %h actual %h", e.out_address, r.out_address);
				errors++;
			end
			if (r.out_type !== e.out_type) begin
				$error("out_type expected %0d actual %0d", e.out_type, r.out_type);
				errors++;
			end
			if (r.last !== e.last) begin
				$error("last expected %0d actual %0d", e.last, r.last);
				errors++;
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             item_valid;
	logic                             item_ready;
	scfb_pkg::item_t                  item;
	logic                             result_valid;
	logic                             result_ready;
	scfb_pkg::result_t                result;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [scfb_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [scfb_pkg::CFG_DATA_W-1:0]  cfg_data;

	front_buffer_sb_t sb = new();
	int send_idle_pct;
	int rx_stall_pct;
	int rx_hold;
	int quiet_cycles;
	bit hold_req;
	bit hold_taken_q;
	logic [23:0] reg_tab [NPHASE][8];

	split_channel_front_buffer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver side: stalls, long hold-off and checking
	always @(negedge clk) begin
		if (hold_req && !hold_taken_q) begin
			hold_taken_q <= 1'b1;
			rx_hold <= 400;
			result_ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			result_ready <= 1'b0;
		end else
			result_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else if (quiet_cycles >= WDOG_MAX) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_word(scfb_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!(item_valid && item_ready));
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [scfb_pkg::CFG_IDX_W-1:0] idx, logic [23:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.set_reg(idx, d);
		@(negedge clk);
	endtask

	function automatic scfb_pkg::item_t make_word(bit cmd, bit [1:0] ty, bit [31:0] a, bit rdy);
		scfb_pkg::item_t it;
		it.command = cmd;
		it.txn_type = ty;
		it.address = a;
		it.ftl_ready = rdy;
		return it;
	endfunction

	function automatic scfb_pkg::item_t rand_word();
		bit [1:0] ty;
		bit [31:0] a;
		int r;
		r = $urandom_range(99);
		ty = r < 40 ? scfb_pkg::TT_READ : (r < 75 ? scfb_pkg::TT_WRITE
			: (r < 95 ? scfb_pkg::TT_RETURN : 2'd3));
		a = $urandom_range(99) < 75 ? 32'($urandom_range(5)) : 32'($urandom);
		return make_word($urandom_range(99) < 45, ty, a, $urandom_range(99) < 80);
	endfunction

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		reg_tab[0] = '{24'd0, 24'd4096, 24'd2048, 24'd64, 24'd256, 24'd64, 24'd64, 24'd16};
		reg_tab[1] = '{24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'd4096, 24'd0, 24'd0, 24'd1024, 24'd0};
		reg_tab[2] = '{24'd3, 24'd3000, 24'd1500, 24'd32, 24'd128, 24'd64, 24'd32, 24'd16};
		reg_tab[3] = '{24'd2, 24'd0, 24'd0, 24'd0, 24'd1, 24'd1, 24'd1, 24'd1};
		reg_tab[4] = '{24'd3, 24'd1000, 24'd1000, 24'h1FFF, 24'hFFFFFF, 24'd1024, 24'd1024,
			24'd1024};
		reg_tab[5] = '{24'd3, 24'hFFFFFF, 24'hFFFFFF, 24'd16, 24'd64, 24'd32, 24'd16, 24'd8};
		reg_tab[6] = '{24'd0, 24'd800, 24'd600, 24'd100, 24'd300, 24'd7, 24'd1023, 24'd1};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int p = 0; p < NPHASE; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; rx_stall_pct = 0; end
				1: begin send_idle_pct = 53; rx_stall_pct = 0; end
				2: begin send_idle_pct = 0; rx_stall_pct = 53; end
				default: begin send_idle_pct = 29; rx_stall_pct = 29; end
			endcase
			for (int r = 0; r < 8; r++) write_reg(REG_IDX[r], reg_tab[p][r]);
			cfg_valid <= 1'b0;
			if (p == 0) begin
				send_word(make_word(1, scfb_pkg::TT_READ, 32'h0, 1));
				send_word(make_word(1, scfb_pkg::TT_WRITE, 32'hFFFFFFFF, 1));
				send_word(make_word(1, scfb_pkg::TT_RETURN, 32'h0, 0));
				send_word(make_word(1, 2'd3, 32'hFFFFFFFF, 1));
				for (int i = 0; i < 4; i++) send_word(make_word(0, 0, 0, 0));
				for (int i = 0; i < 12; i++) send_word(make_word(0, 2'd3, 32'hFFFFFFFF, 1));
				for (int i = 0; i < 4; i++)
					send_word(make_word(1, scfb_pkg::TT_WRITE, 32'(i), 1));
			end
			if (p == 5) hold_req = 1'b1;
			for (int i = 0; i < 50; i++) send_word(rand_word());
			drain();
		end
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
